@@ design/pdmg_pkg.sv @@
// Shared types, constants and tables of the push detector and motor guard.
package pdmg_pkg;

	localparam int CORDIC_ITERS = 16;
	localparam int CordicN = (CORDIC_ITERS < 32) ? CORDIC_ITERS : 32;
	localparam int ItW = (CordicN > 1) ? $clog2(CordicN) : 1;
	localparam int CW = 52;
	localparam int AW = 21;

	localparam logic [1:0] CMD_ODOM   = 2'd0;
	localparam logic [1:0] CMD_VEL    = 2'd1;
	localparam logic [1:0] CMD_MOTOR  = 2'd2;
	localparam logic [1:0] CMD_POSE   = 2'd3;

	localparam logic [1:0] REG_STEADY = 2'd0;
	localparam logic [1:0] REG_DIST   = 2'd1;
	localparam logic [1:0] REG_ANGLE  = 2'd2;

	localparam logic [1:0] KIND_MOTOR  = 2'd0;
	localparam logic [1:0] KIND_EDGE   = 2'd1;
	localparam logic [1:0] KIND_REPORT = 2'd2;

	localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;
	localparam logic signed [AW-1:0] HALF_PI_Q16 = AW'(102944);
	localparam logic signed [AW+2:0] PI_Q16      = (AW+3)'(205887);
	localparam logic signed [AW+2:0] TWO_PI_Q16  = (AW+3)'(411775);
	localparam logic [27:0] INV_GAIN_Q28 = 28'd163008219;
	localparam logic [15:0] ANGLE_MAX    = 16'd51472;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] qz;
		logic signed [15:0] qw;
	} pose_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        en;
		logic        rs;
		logic        sg;
		logic        tg;
		pose_t       pose;
		logic [32:0] travel;
		logic [15:0] ang;
		logic        last;
	} res_t;

	typedef struct packed {
		logic  job;
		res_t  res;
		pose_t start;
	} task_t;

	typedef struct packed {
		logic [15:0] steady_limit;
		logic [31:0] distance_threshold;
		logic [15:0] angle_threshold;
	} cfg_t;

	function automatic logic signed [AW-1:0] atan_q16(input logic [4:0] i);
		logic signed [AW-1:0] r;
		begin
			case (i)
				5'd0: r = AW'(51472);
				5'd1: r = AW'(30386);
				5'd2: r = AW'(16055);
				5'd3: r = AW'(8150);
				5'd4: r = AW'(4091);
				5'd5: r = AW'(2047);
				5'd6: r = AW'(1024);
				5'd7: r = AW'(512);
				5'd8: r = AW'(256);
				5'd9: r = AW'(128);
				5'd10: r = AW'(64);
				5'd11: r = AW'(32);
				5'd12: r = AW'(16);
				5'd13: r = AW'(8);
				5'd14: r = AW'(4);
				5'd15: r = AW'(2);
				5'd16: r = AW'(1);
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

@@ design/push_detect_motor_guard_core.sv @@
// Top level of the push detector and motor guard.
// Result path: with the back end idle, a word with a direct result is registered in the
// task queue and then in the result queue before it shows on the result ports; a
// free-run end started by the guard runs three CORDIC passes (INIT, then ITER per
// iteration), then MUL0, MUL1 and EDGE, and REP when a report is due.
// Throughput: one word a cycle while the task queue has room; the shared CORDIC unit
// takes one guard run end at a time; the back end takes a new task only when idle.
// Reset (arst_n low, asynchronous): registers to defaults, queues empty.
module push_detect_motor_guard_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         command,
	input  logic               wheels_still,
	input  logic               command_zero,
	input  logic               motors_off,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         result_kind,
	output logic               motor_enable,
	output logic               run_started,
	output logic               started_by_guard,
	output logic               stopped_by_guard,
	output logic signed [31:0] pose_x,
	output logic signed [31:0] pose_y,
	output logic signed [15:0] pose_qz,
	output logic signed [15:0] pose_qw,
	output logic [32:0]        moved_distance,
	output logic [15:0]        turned_angle,
	output logic               last
);

	pdmg_pkg::cfg_t  cfg_q;
	logic            accept;
	logic            task_push;
	pdmg_pkg::task_t task_word;
	logic            task_valid;
	pdmg_pkg::task_t task_head;
	logic            task_pop;
	pdmg_pkg::res_t  head_res;

	// Registers must be written only while idle (the block does not enforce it); always take the word
	assign cfg_ready = 1'b1;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steady_limit <= 16'd30;
			cfg_q.distance_threshold <= 32'd13107;
			cfg_q.angle_threshold <= 16'd819;
		end else if (cfg_valid) begin
			case (cfg_index)
				pdmg_pkg::REG_STEADY: cfg_q.steady_limit <= cfg_data[15:0];
				pdmg_pkg::REG_DIST: cfg_q.distance_threshold <= cfg_data;
				pdmg_pkg::REG_ANGLE: cfg_q.angle_threshold <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Front: classify the word and update guard state at once
	pdmg_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .command(command),
		.wheels_still(wheels_still), .command_zero(command_zero), .motors_off(motors_off),
		.pos_x(pos_x), .pos_y(pos_y), .quat_z(quat_z), .quat_w(quat_w),
		.steady_limit(cfg_q.steady_limit), .task_push(task_push), .task_word(task_word)
	);

	// Hold tasks until the back end is free
	pdmg_task_q u_task_q (
		.clk(clk), .arst_n(arst_n), .push(task_push), .push_word(task_word),
		.pop(task_pop), .full(full), .valid(task_valid), .head_word(task_head)
	);

	// Back: run CORDIC and deliver results in order
	pdmg_back u_back (
		.clk(clk), .arst_n(arst_n), .task_valid(task_valid), .task_word(task_head),
		.task_pop(task_pop), .cfg(cfg_q), .pop(pop), .empty(empty), .head_res(head_res)
	);

	assign result_kind = head_res.kind;
	assign motor_enable = head_res.en;
	assign run_started = head_res.rs;
	assign started_by_guard = head_res.sg;
	assign stopped_by_guard = head_res.tg;
	assign pose_x = head_res.pose.x;
	assign pose_y = head_res.pose.y;
	assign pose_qz = head_res.pose.qz;
	assign pose_qw = head_res.pose.qw;
	assign moved_distance = head_res.travel;
	assign turned_angle = head_res.ang;
	assign last = head_res.last;

endmodule

@@ design/pdmg_front.sv @@
// Front end: takes event words, keeps the guard state and issues tasks.
module pdmg_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [1:0]             command,
	input  logic                   wheels_still,
	input  logic                   command_zero,
	input  logic                   motors_off,
	input  logic signed [31:0]     pos_x,
	input  logic signed [31:0]     pos_y,
	input  logic signed [15:0]     quat_z,
	input  logic signed [15:0]     quat_w,
	input  logic [15:0]            steady_limit,
	output logic                   task_push,
	output pdmg_pkg::task_t        task_word
);

	logic [16:0]     still_count_q;
	logic            cmd_stopped_q;
	logic            in_free_run_q;
	logic            gsr_q;
	logic            gstop_q;
	pdmg_pkg::pose_t cur_q;
	pdmg_pkg::pose_t start_q;
	logic            long_stand;

	assign long_stand = still_count_q > {1'b0, steady_limit};

	always_comb begin
		task_push = 1'b0;
		task_word = '0;
		task_word.start = start_q;
		task_word.res.last = 1'b1;
		if (accept) begin
			case (command)
				pdmg_pkg::CMD_ODOM: begin
					if (long_stand && !wheels_still && !in_free_run_q) begin
						task_push = 1'b1;
						task_word.res.kind = pdmg_pkg::KIND_MOTOR;
					end else if (long_stand && wheels_still && in_free_run_q && gsr_q) begin
						task_push = 1'b1;
						task_word.res.kind = pdmg_pkg::KIND_MOTOR;
						task_word.res.en = 1'b1;
					end
				end
				pdmg_pkg::CMD_MOTOR: begin
					if (motors_off != in_free_run_q) begin
						task_push = 1'b1;
						task_word.res.kind = pdmg_pkg::KIND_EDGE;
						task_word.res.rs = motors_off;
						task_word.res.sg = gsr_q;
						task_word.res.tg = gstop_q;
						task_word.res.pose = cur_q;
						task_word.job = !motors_off && gsr_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_count_q <= '0;
			cmd_stopped_q <= 1'b1;
			in_free_run_q <= 1'b0;
			gsr_q <= 1'b0;
			gstop_q <= 1'b0;
			cur_q <= '0;
			start_q <= '0;
		end else if (accept) begin
			case (command)
				pdmg_pkg::CMD_ODOM: begin
					if (long_stand && !wheels_still && !in_free_run_q)
						gsr_q <= 1'b1;
					if (long_stand && wheels_still && in_free_run_q && gsr_q)
						gstop_q <= 1'b1;
					if (cmd_stopped_q && wheels_still) begin
						if (still_count_q != pdmg_pkg::COUNT_MAX)
							still_count_q <= still_count_q + 17'd1;
					end else begin
						still_count_q <= '0;
					end
				end
				pdmg_pkg::CMD_VEL: cmd_stopped_q <= command_zero;
				pdmg_pkg::CMD_MOTOR: begin
					if (motors_off != in_free_run_q) begin
						if (motors_off) begin
							start_q <= cur_q;
						end else if (gsr_q) begin
							gsr_q <= 1'b0;
							gstop_q <= 1'b0;
						end
					end
					in_free_run_q <= motors_off;
				end
				default: begin
					cur_q.x <= pos_x;
					cur_q.y <= pos_y;
					cur_q.qz <= quat_z;
					cur_q.qw <= quat_w;
				end
			endcase
		end
	end

endmodule

@@ design/pdmg_task_q.sv @@
// Two-entry task queue between front and back.
module pdmg_task_q (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pdmg_pkg::task_t  push_word,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output pdmg_pkg::task_t  head_word
);

	pdmg_pkg::task_t ent_q [2];
	logic            head_q;
	logic [1:0]      cnt_q;
	logic            wr_idx;

	assign full = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign head_word = ent_q[head_q];
	assign wr_idx = head_q ^ cnt_q[0];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_idx] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (pop)
				head_q <= ~head_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ design/pdmg_back.sv @@
// Back end: runs tasks, computes distance and angle by CORDIC, queues results.
module pdmg_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             task_valid,
	input  pdmg_pkg::task_t  task_word,
	output logic             task_pop,
	input  pdmg_pkg::cfg_t   cfg,
	input  logic             pop,
	output logic             empty,
	output pdmg_pkg::res_t   head_res
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_INIT = 7'b0000010,
		S_ITER = 7'b0000100,
		S_MUL0 = 7'b0001000,
		S_MUL1 = 7'b0010000,
		S_EDGE = 7'b0100000,
		S_REP  = 7'b1000000
	} state_t;

	state_t                          state_q;
	pdmg_pkg::task_t                 job_q;
	logic [1:0]                      pass_q;
	logic [pdmg_pkg::ItW-1:0]        it_q;
	logic signed [pdmg_pkg::CW-1:0]  x_q, y_q;
	logic signed [pdmg_pkg::AW-1:0]  acc_q, a0_q, a1_q;
	logic                            zv_q;
	logic [35:0]                     mag_q;
	logic [45:0]                     prod_q;
	logic [45:0]                     prodh_q;
	logic [32:0]                     dist_q;
	logic [15:0]                     q_q;

	pdmg_pkg::res_t ent_q [2];
	logic           head_q;
	logic [1:0]     cnt_q;
	logic           space;
	logic           opush;
	pdmg_pkg::res_t opush_word;

	logic signed [pdmg_pkg::CW-1:0] sx, sy;
	logic signed [pdmg_pkg::CW-1:0] xn;
	logic signed [32:0]             dx, dy;
	logic signed [15:0]             vz, vw;
	logic signed [pdmg_pkg::CW-1:0] iz, iw;
	logic signed [pdmg_pkg::AW+2:0] ad, aa;
	logic [pdmg_pkg::AW+3:0]        qr;
	logic [63:0]                    psum;
	logic                           rep;

	assign space = cnt_q != 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head_res = ent_q[head_q];

	assign sx = x_q >>> it_q;
	assign sy = y_q >>> it_q;
	assign xn = (y_q >= 0) ? x_q + sy : x_q - sy;
	assign dx = {job_q.res.pose.x[31], job_q.res.pose.x} - {job_q.start.x[31], job_q.start.x};
	assign dy = {job_q.res.pose.y[31], job_q.res.pose.y} - {job_q.start.y[31], job_q.start.y};
	assign vz = (pass_q == 2'd1) ? job_q.start.qz : job_q.res.pose.qz;
	assign vw = (pass_q == 2'd1) ? job_q.start.qw : job_q.res.pose.qw;
	assign iz = {{(pdmg_pkg::CW-32){vz[15]}}, vz, 16'd0};
	assign iw = {{(pdmg_pkg::CW-32){vw[15]}}, vw, 16'd0};

	// Fold the angle difference into 0..pi
	always_comb begin
		ad = ((pdmg_pkg::AW+3)'(a0_q) - (pdmg_pkg::AW+3)'(a1_q)) <<< 1;
		if (ad < 0)
			ad = -ad;
		aa = ad;
		if (ad > pdmg_pkg::PI_Q16) begin
			aa = ad - pdmg_pkg::TWO_PI_Q16;
			if (aa < 0)
				aa = -aa;
		end
		qr = ((pdmg_pkg::AW+4)'(aa) + (pdmg_pkg::AW+4)'(4)) >> 3;
	end

	assign psum = 64'(prod_q) + (64'(prodh_q) << 18) + (64'd1 << 27);
	assign rep = (q_q > cfg.angle_threshold) || (dist_q > {1'b0, cfg.distance_threshold});

	always_comb begin
		opush = 1'b0;
		opush_word = job_q.res;
		task_pop = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (task_valid && !task_word.job && space) begin
					opush = 1'b1;
					opush_word = task_word.res;
					task_pop = 1'b1;
				end else if (task_valid && task_word.job) begin
					task_pop = 1'b1;
				end
			end
			S_EDGE: begin
				opush = space;
				opush_word.last = !rep;
			end
			S_REP: begin
				opush = space;
				opush_word.kind = pdmg_pkg::KIND_REPORT;
				opush_word.rs = 1'b0;
				opush_word.sg = 1'b1;
				opush_word.travel = dist_q;
				opush_word.ang = q_q;
				opush_word.last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (opush)
			ent_q[head_q ^ cnt_q[0]] <= opush_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (pop && !empty)
				head_q <= ~head_q;
			cnt_q <= cnt_q + {1'b0, opush} - {1'b0, pop && !empty};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q <= '0;
			it_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (task_valid && task_word.job) begin
						state_q <= S_INIT;
						pass_q <= '0;
					end
				end
				S_INIT: begin
					it_q <= '0;
					state_q <= S_ITER;
				end
				S_ITER: begin
					if (it_q == pdmg_pkg::ItW'(pdmg_pkg::CordicN - 1)) begin
						if (pass_q == 2'd2) begin
							state_q <= S_MUL0;
						end else begin
							pass_q <= pass_q + 2'd1;
							state_q <= S_INIT;
						end
					end else begin
						it_q <= it_q + pdmg_pkg::ItW'(1);
					end
				end
				S_MUL0: state_q <= S_MUL1;
				S_MUL1: state_q <= S_EDGE;
				S_EDGE: if (space) state_q <= rep ? S_REP : S_IDLE;
				S_REP: if (space) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (task_valid && task_word.job) job_q <= task_word;
			S_INIT: begin
				zv_q <= 1'b0;
				acc_q <= '0;
				if (pass_q == 2'd0) begin
					x_q <= {{(pdmg_pkg::CW-49){1'b0}}, (dx < 0 ? -dx : dx), 16'd0};
					y_q <= {{(pdmg_pkg::CW-49){1'b0}}, (dy < 0 ? -dy : dy), 16'd0};
				end else begin
					zv_q <= (vz == 16'sd0) && (vw == 16'sd0);
					x_q <= iz;
					y_q <= iw;
					if (iz < 0) begin
						if (iw >= 0) begin
							x_q <= iw;
							y_q <= -iz;
							acc_q <= pdmg_pkg::HALF_PI_Q16;
						end else begin
							x_q <= -iw;
							y_q <= iz;
							acc_q <= -pdmg_pkg::HALF_PI_Q16;
						end
					end
				end
			end
			S_ITER: begin
				if (y_q >= 0) begin
					x_q <= x_q + sy;
					y_q <= y_q - sx;
					acc_q <= acc_q + pdmg_pkg::atan_q16(5'(it_q));
				end else begin
					x_q <= x_q - sy;
					y_q <= y_q + sx;
					acc_q <= acc_q - pdmg_pkg::atan_q16(5'(it_q));
				end
				if (it_q == pdmg_pkg::ItW'(pdmg_pkg::CordicN - 1)) begin
					case (pass_q)
						2'd0: mag_q <= xn[51:16] + 36'(xn[15]);
						2'd1: a0_q <= zv_q ? '0 : ((y_q >= 0) ?
							acc_q + pdmg_pkg::atan_q16(5'(it_q)) :
							acc_q - pdmg_pkg::atan_q16(5'(it_q)));
						default: a1_q <= zv_q ? '0 : ((y_q >= 0) ?
							acc_q + pdmg_pkg::atan_q16(5'(it_q)) :
							acc_q - pdmg_pkg::atan_q16(5'(it_q)));
					endcase
				end
			end
			S_MUL0: begin
				prod_q <= mag_q[17:0] * pdmg_pkg::INV_GAIN_Q28;
				prodh_q <= mag_q[35:18] * pdmg_pkg::INV_GAIN_Q28;
				q_q <= (qr > (pdmg_pkg::AW+4)'(pdmg_pkg::ANGLE_MAX)) ?
					pdmg_pkg::ANGLE_MAX : qr[15:0];
			end
			S_MUL1: begin
				dist_q <= (psum[63:28] > 36'h1FFFFFFFF) ? 33'h1FFFFFFFF : psum[60:28];
			end
			default: ;
		endcase
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("result queue overflow");
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ITER |-> pass_q <= 2'd2)
		else $error("bad CORDIC pass");
	a_rep_last: assert property (@(posedge clk) disable iff (!arst_n)
		opush && opush_word.kind == pdmg_pkg::KIND_REPORT |-> opush_word.last)
		else $error("report not last");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		task_pop |-> task_valid)
		else $error("task popped from empty queue");

endmodule

@@ test/tb_push_detect_motor_guard_core.sv @@
// Testbench for the push detector and motor guard: scoreboard with its own guard predictor.
module tb_push_detect_motor_guard_core;

	// one expected or observed result word
	typedef struct {
		logic [1:0]  kind;
		logic        en;
		logic        rs;
		logic        sg;
		logic        tg;
		logic [31:0] px;
		logic [31:0] py;
		logic [15:0] qz;
		logic [15:0] qw;
		logic [32:0] travel;
		logic [15:0] ang;
		logic        last;
	} guard_word_t;

	int fail_count = 0;

	// Print one line for a mismatch and count it.
	task automatic report_mismatch(input string what);
		$display("ERROR %s", what);
		fail_count++;
	endtask

	// Guard predictor and store of pending guard words.
	class guard_scoreboard;
		logic [15:0] steady_limit;
		logic [31:0] dist_limit;
		logic [15:0] angle_limit;
		int unsigned still_count;
		bit cmd_stopped, in_run, guard_started, guard_stopped;
		longint cur_x, cur_y, st_x, st_y;
		int cur_qz, cur_qw, st_qz, st_qw;
		guard_word_t pending[$];

		function new();
			steady_limit = 16'd30;
			dist_limit = 32'd13107;
			angle_limit = 16'd819;
			still_count = 0;
			cmd_stopped = 1;
			in_run = 0;
			guard_started = 0;
			guard_stopped = 0;
			cur_x = 0; cur_y = 0; st_x = 0; st_y = 0;
			cur_qz = 0; cur_qw = 0; st_qz = 0; st_qw = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			if (idx == pdmg_pkg::REG_STEADY) steady_limit = val[15:0];
			else if (idx == pdmg_pkg::REG_DIST) dist_limit = val;
			else if (idx == pdmg_pkg::REG_ANGLE) angle_limit = val[15:0];
		endfunction

		// arithmetic shift right that floors, as the hardware does
		function longint shr(longint v, int s);
			return v >>> s;
		endfunction

		function longint heading(int z, int w);
			longint x, y, t, acc;
			int n;
			x = longint'(z) * 65536;
			y = longint'(w) * 65536;
			acc = 0;
			n = (pdmg_pkg::CORDIC_ITERS < 32) ? pdmg_pkg::CORDIC_ITERS : 32;
			if (z == 0 && w == 0) return 0;
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; acc = 102944;
				end else begin
					t = x; x = -y; y = t; acc = -102944;
				end
			end
			for (int i = 0; i < n; i++) begin
				longint sx, sy;
				sx = shr(x, i);
				sy = shr(y, i);
				if (y >= 0) begin
					x += sy; y -= sx; acc += pdmg_pkg::atan_q16(i[4:0]);
				end else begin
					x -= sy; y += sx; acc -= pdmg_pkg::atan_q16(i[4:0]);
				end
			end
			return acc;
		endfunction

		function logic [32:0] span(longint dx, longint dy);
			longint x, y;
			longint unsigned m, p;
			int n;
			n = (pdmg_pkg::CORDIC_ITERS < 32) ? pdmg_pkg::CORDIC_ITERS : 32;
			x = (dx < 0 ? -dx : dx) * 65536;
			y = (dy < 0 ? -dy : dy) * 65536;
			for (int i = 0; i < n; i++) begin
				longint sx, sy;
				sx = shr(x, i);
				sy = shr(y, i);
				if (y >= 0) begin
					x += sy; y -= sx;
				end else begin
					x -= sy; y += sx;
				end
			end
			m = (longint'(x) + 32768) >> 16;
			p = (m * 163008219 + (64'd1 << 27)) >> 28;
			return (p > 64'h1FFFFFFFF) ? 33'h1FFFFFFFF : p[32:0];
		endfunction

		function guard_word_t blank(logic [1:0] kind);
			guard_word_t w;
			w = '{kind: kind, default: '0};
			return w;
		endfunction

		function guard_word_t with_pose(guard_word_t w);
			w.px = cur_x[31:0];
			w.py = cur_y[31:0];
			w.qz = cur_qz[15:0];
			w.qw = cur_qw[15:0];
			return w;
		endfunction

		// Work out the words that one accepted input word causes.
		function void note_input(logic [1:0] cmd, bit still, bit czero, bit fr,
					logic [31:0] x, logic [31:0] y, logic [15:0] z, logic [15:0] w);
			guard_word_t out[$];
			guard_word_t r;
			bit long_stand;
			if (cmd == pdmg_pkg::CMD_ODOM) begin
				long_stand = still_count > steady_limit;
				if (long_stand && !still && !in_run) begin
					r = blank(pdmg_pkg::KIND_MOTOR);
					out.push_back(r);
					guard_started = 1;
				end
				if (long_stand && still && in_run && guard_started) begin
					r = blank(pdmg_pkg::KIND_MOTOR);
					r.en = 1;
					out.push_back(r);
					guard_stopped = 1;
				end
				if (cmd_stopped && still) begin
					if (still_count < 131071) still_count++;
				end else begin
					still_count = 0;
				end
			end else if (cmd == pdmg_pkg::CMD_VEL) begin
				cmd_stopped = czero;
			end else if (cmd == pdmg_pkg::CMD_MOTOR) begin
				if (fr != in_run) begin
					r = with_pose(blank(pdmg_pkg::KIND_EDGE));
					r.rs = fr;
					r.sg = guard_started;
					r.tg = guard_stopped;
					out.push_back(r);
					if (fr) begin
						st_x = cur_x; st_y = cur_y; st_qz = cur_qz; st_qw = cur_qw;
					end else if (guard_started) begin
						logic [32:0] d;
						longint a;
						longint unsigned q;
						d = span(cur_x - st_x, cur_y - st_y);
						a = 2 * (heading(st_qz, st_qw) - heading(cur_qz, cur_qw));
						if (a < 0) a = -a;
						if (a > 205887) begin
							a -= 411775;
							if (a < 0) a = -a;
						end
						q = (a + 4) >> 3;
						if (q > 51472) q = 51472;
						if (q > angle_limit || d > dist_limit) begin
							r = with_pose(blank(pdmg_pkg::KIND_REPORT));
							r.sg = 1;
							r.tg = guard_stopped;
							r.travel = d;
							r.ang = q[15:0];
							out.push_back(r);
						end
						guard_started = 0;
						guard_stopped = 0;
					end
				end
				in_run = fr;
			end else begin
				cur_x = longint'($signed(x));
				cur_y = longint'($signed(y));
				cur_qz = int'($signed(z));
				cur_qw = int'($signed(w));
			end
			if (out.size() > 0) out[out.size()-1].last = 1;
			foreach (out[i]) pending.push_back(out[i]);
		endfunction

		// Compare one popped word with the oldest expectation.
		task check_result(guard_word_t got);
			guard_word_t e;
			if (pending.size() == 0) begin
				report_mismatch("result word with nothing expected");
				return;
			end
			e = pending.pop_front();
			if (got.kind !== e.kind) report_mismatch($sformatf("kind %0d/%0d", got.kind, e.kind));
			if (got.en !== e.en) report_mismatch("motor_enable");
			if (got.rs !== e.rs) report_mismatch("run_started");
			if (got.sg !== e.sg) report_mismatch("started_by_guard");
			if (got.tg !== e.tg) report_mismatch("stopped_by_guard");
			if (got.px !== e.px) report_mismatch("pose_x");
			if (got.py !== e.py) report_mismatch("pose_y");
			if (got.qz !== e.qz) report_mismatch("pose_qz");
			if (got.qw !== e.qw) report_mismatch("pose_qw");
			if (got.travel !== e.travel)
				report_mismatch($sformatf("moved_distance %0d/%0d", got.travel, e.travel));
			if (got.ang !== e.ang)
				report_mismatch($sformatf("turned_angle %0d/%0d", got.ang, e.ang));
			if (got.last !== e.last) report_mismatch("last");
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic [1:0] command = pdmg_pkg::CMD_ODOM;
	logic wheels_still = 0, command_zero = 0, motors_off = 0;
	logic signed [31:0] pos_x = 0, pos_y = 0;
	logic signed [15:0] quat_z = 0, quat_w = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = pdmg_pkg::REG_STEADY;
	logic [31:0] cfg_data = 0;
	logic empty;
	logic pop = 0;
	logic [1:0] result_kind;
	logic motor_enable, run_started, started_by_guard, stopped_by_guard, last;
	logic signed [31:0] pose_x, pose_y;
	logic signed [15:0] pose_qz, pose_qw;
	logic [32:0] moved_distance;
	logic [15:0] turned_angle;

	guard_scoreboard sb = new();
	longint cycle = 0;
	bit pop_on = 1;
	bit long_stalls = 1;
	int pop_hold = 0;

	push_detect_motor_guard_core u_top (.*);

	always #4 clk = ~clk;

	// Hold a generous limit on the run length.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 2000000) begin
			$display("push_detect_motor_guard_core: mismatch");
			$finish;
		end
	end

	// Drain side: check each popped word, then vary pop at random.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			guard_word_t got;
			got = '{kind: result_kind, en: motor_enable, rs: run_started,
				sg: started_by_guard, tg: stopped_by_guard, px: pose_x, py: pose_y,
				qz: pose_qz, qw: pose_qw, travel: moved_distance, ang: turned_angle,
				last: last};
			sb.check_result(got);
		end
		if (pop_hold > 0) begin
			pop_hold <= pop_hold - 1;
			pop <= 0;
		end else if (!pop_on) pop <= 1;
		else if ($urandom_range(0, 99) < 25) pop <= 0;
		else if ($urandom_range(0, 99) < 2 && long_stalls) begin
			pop_hold <= $urandom_range(10, 60);
			pop <= 0;
		end else pop <= 1;
	end

	// Random gap before the next word: mostly short, a few long.
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 99) < 60) ? 0 :
			($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
		if (n > 0) begin
			push <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Offer one word and hold it until accepted.
	task automatic send_word(input logic [1:0] cmd, input bit st, input bit cz, input bit fr,
				input logic [31:0] x, input logic [31:0] y,
				input logic [15:0] z, input logic [15:0] w);
		push <= 1;
		command <= cmd; wheels_still <= st; command_zero <= cz; motors_off <= fr;
		pos_x <= x; pos_y <= y; quat_z <= z; quat_w <= w;
		do @(posedge clk); while (full);
		sb.note_input(cmd, st, cz, fr, x, y, z, w);
		idle_gap();
	endtask

	task automatic send_odom(input bit st);
		send_word(pdmg_pkg::CMD_ODOM, st, 1'($urandom), 1'($urandom), $urandom, $urandom,
			16'($urandom), 16'($urandom));
	endtask

	task automatic send_vel(input bit cz);
		send_word(pdmg_pkg::CMD_VEL, 1'($urandom), cz, 1'($urandom), $urandom, $urandom,
			16'($urandom), 16'($urandom));
	endtask

	task automatic send_motor(input bit fr);
		send_word(pdmg_pkg::CMD_MOTOR, 1'($urandom), 1'($urandom), fr, $urandom, $urandom,
			16'($urandom), 16'($urandom));
	endtask

	function automatic logic [15:0] rand_quat();
		int v;
		v = $urandom_range(0, 32768);
		return 16'(v - 16384);
	endfunction

	task automatic send_pose(input logic [31:0] x, input logic [31:0] y,
				input logic [15:0] z, input logic [15:0] w);
		send_word(pdmg_pkg::CMD_POSE, 1'($urandom), 1'($urandom), 1'($urandom), x, y, z, w);
	endtask

	// Wait for every pending word, then let the CORDIC settle.
	task automatic drain();
		push <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		push <= 0;
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// One guard-started run: stand, push, optionally stand again, release.
	task automatic guard_episode(input int stand, input bit restore);
		send_vel(1'b1);
		repeat (stand) send_odom(1'b1);
		send_odom(1'b0);
		send_motor(1'b1);
		send_pose($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000) - 100000,
			$urandom_range(0, 200000) - 100000, rand_quat(), rand_quat());
		if (restore) repeat (stand + 2) send_odom(1'b1);
		send_motor(1'b0);
	endtask

	initial begin
		int items;
		int stand;
		bit restore;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: default registers, extremes and every command.
		send_pose(32'h7FFFFFFF, 32'h80000000, 16'sd16384, -16'sd16384);
		send_vel(1'b0);
		send_odom(1'b1);
		send_motor(1'b0);
		write_reg(pdmg_pkg::REG_STEADY, 32'd2);
		guard_episode(3, 1'b1);
		send_pose(32'h80000000, 32'h7FFFFFFF, -16'sd16384, 16'sd0);
		send_motor(1'b1);
		send_motor(1'b1);
		send_motor(1'b0);
		send_pose(32'd0, 32'd0, 16'd0, 16'd0);
		guard_episode(3, 1'b0);
		send_pose(32'hFFFFFFFF, 32'h00000001, 16'sd16384, 16'sd16384);
		send_motor(1'b0);
		drain();

		// Register extremes: largest thresholds, then zero thresholds and steady limit, draining after each.
		write_reg(pdmg_pkg::REG_DIST, 32'hFFFFFFFF);
		write_reg(pdmg_pkg::REG_ANGLE, 32'd51472);
		guard_episode(2, 1'b1);
		drain();
		write_reg(pdmg_pkg::REG_DIST, 32'd0);
		write_reg(pdmg_pkg::REG_ANGLE, 32'd0);
		write_reg(pdmg_pkg::REG_STEADY, 32'd0);
		guard_episode(1, 1'b1);
		drain();

		// Random phases across several register settings.
		for (int ph = 0; ph < 6; ph++) begin
			long_stalls = ph != 2;
			pop_on = ph != 3;
			write_reg(pdmg_pkg::REG_STEADY, (ph == 5) ? 32'd65535 : $urandom_range(0, 6));
			write_reg(pdmg_pkg::REG_DIST, (ph == 4) ? 32'd0 : $urandom_range(0, 200000));
			write_reg(pdmg_pkg::REG_ANGLE, $urandom_range(0, 51472));
			items = 0;
			while (items < 210) begin
				if ($urandom_range(0, 99) < 70) begin
					stand = $urandom_range(0, 8);
					restore = 1'($urandom);
					guard_episode(stand, restore);
					items += 4 + stand + (restore ? stand + 2 : 0);
				end else begin
					case ($urandom_range(0, 3))
						0: send_odom(1'($urandom));
						1: send_vel(1'($urandom));
						2: send_motor(1'($urandom));
						default: send_pose($urandom, $urandom, rand_quat(), rand_quat());
					endcase
					items++;
				end
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("push_detect_motor_guard_core: match");
		end else begin
			$display("push_detect_motor_guard_core: mismatch");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
design/pdmg_pkg.sv
design/pdmg_front.sv
design/pdmg_task_q.sv
design/pdmg_back.sv
design/push_detect_motor_guard_core.sv
test/tb_push_detect_motor_guard_core.sv
